@@ hdl/lfps_pkg.sv @@
// Shared widths, the base speed reset value and configuration register indexes for the line follower steering block.
package lfps_pkg;

    localparam int LFPS_SUM_WIDTH = 16;

    localparam int SENSOR_W    = 8;
    localparam int ERR_W       = 4;
    localparam int GAIN_W      = 16;
    localparam int BASE_W      = 15;
    localparam int PID_W       = 32;
    localparam int SPEED_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [BASE_W-1:0] BASE_SPEED_RST = BASE_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P       = 3'd0,
        CFG_GAIN_I       = 3'd1,
        CFG_GAIN_D       = 3'd2,
        CFG_GAIN_P_SHARP = 3'd3,
        CFG_GAIN_D_SHARP = 3'd4,
        CFG_BASE_SPEED   = 3'd5
    } t_cfg_idx;

endpackage

@@ hdl/lfps_in_if.sv @@
// Valid/ready channel carrying one sensor sample beat.
interface lfps_in_if import lfps_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_bits;
    logic                sample_due;

    modport source (output valid, sensor_bits, sample_due, input ready);
    modport sink   (input valid, sensor_bits, sample_due, output ready);

endinterface

@@ hdl/lfps_out_if.sv @@
// Valid/ready channel carrying one steering result beat.
interface lfps_out_if import lfps_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [ERR_W-1:0]  position_error;
    logic signed [PID_W-1:0]  pid_value;
    logic [SPEED_W-1:0]       right_speed;
    logic                     right_reverse;
    logic [SPEED_W-1:0]       left_speed;
    logic                     left_reverse;

    modport source (output valid, position_error, pid_value, right_speed, right_reverse,
                    left_speed, left_reverse, input ready);
    modport sink   (input valid, position_error, pid_value, right_speed, right_reverse,
                    left_speed, left_reverse, output ready);

endinterface

@@ hdl/line_follower_pid_steer_top.sv @@
// Each sample beat passes the input register, the controller state and the result register.
// Throughput: one beat per cycle while o_out.ready allows; the PID update (decoder, three
// multiplies, clamp) is combinational between the input register and the controller state.
// Wheel speeds are formed from the controller state into the result register.
// Reset (synchronous, active low) empties the pipeline, zeroes gains and PID state
// and sets the base speed to 1.0.
module line_follower_pid_steer_top import lfps_pkg::*; #(
    parameter int SUM_WIDTH = LFPS_SUM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lfps_in_if.sink               i_in,
    lfps_out_if.source            o_out
);

    localparam int ACC_W = (GAIN_W + SUM_WIDTH + 2 > PID_W + 2) ?
                           (GAIN_W + SUM_WIDTH + 2) : (PID_W + 2);
    localparam int WHL_W = PID_W + 2;

    // configuration
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d, r_gain_p_sharp, r_gain_d_sharp;
    logic [BASE_W-1:0]        r_base;

    // pipeline
    logic                r_v1, r_v2, r_v3;
    logic [SENSOR_W-1:0] r_sens1;
    logic                r_due1;
    logic                adv1, adv2, adv3;

    // controller state, also the payload of the middle stage
    logic signed [ERR_W-1:0]     r_last_err;
    logic signed [SUM_WIDTH-1:0] r_err_sum;
    logic signed [PID_W-1:0]     r_held;

    // result register
    logic signed [ERR_W-1:0] r_out_err;
    logic signed [PID_W-1:0] r_out_pid;
    logic [SPEED_W-1:0]      r_out_rspd, r_out_lspd;
    logic                    r_out_rrev, r_out_lrev;

    // update logic
    logic                          lost;
    logic signed [ERR_W-1:0]       err;
    logic signed [SUM_WIDTH:0]     sum_wide;
    logic signed [SUM_WIDTH-1:0]   sum_sat;
    logic signed [SUM_WIDTH-1:0]   n_err_sum;
    logic signed [GAIN_W-1:0]      gp, gd;
    logic signed [ERR_W:0]         dterm;
    logic signed [GAIN_W+ERR_W-1:0]     prod_p;
    logic signed [GAIN_W+ERR_W:0]       prod_d;
    logic signed [GAIN_W+SUM_WIDTH-1:0] prod_i;
    logic signed [ACC_W-1:0]       acc;
    logic [ACC_W-PID_W:0]          acc_hi;
    logic signed [PID_W-1:0]       n_held;

    // wheel logic
    logic signed [WHL_W-1:0] right_sum, left_sum;
    logic [SPEED_W:0]        right_w, left_w;

    function automatic logic [SPEED_W:0] f_wheel(input logic signed [WHL_W-1:0] v);
        logic [WHL_W-1:0]   mag;
        logic [SPEED_W-1:0] spd;
        mag = v[WHL_W-1] ? WHL_W'(-v) : WHL_W'(v);
        spd = (|mag[WHL_W-1:SPEED_W]) ? '1 : mag[SPEED_W-1:0];
        return {v[WHL_W-1], spd};
    endfunction

    // handshake: each stage advances when its successor has room
    assign adv3       = !r_v3 || o_out.ready;
    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign i_in.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= '0;
            r_gain_i       <= '0;
            r_gain_d       <= '0;
            r_gain_p_sharp <= '0;
            r_gain_d_sharp <= '0;
            r_base         <= BASE_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:       r_gain_p       <= i_cfg_data;
                CFG_GAIN_I:       r_gain_i       <= i_cfg_data;
                CFG_GAIN_D:       r_gain_d       <= i_cfg_data;
                CFG_GAIN_P_SHARP: r_gain_p_sharp <= i_cfg_data;
                CFG_GAIN_D_SHARP: r_gain_d_sharp <= i_cfg_data;
                CFG_BASE_SPEED:   r_base         <= i_cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // position decoder, priority from centre outward
    always_comb begin
        lost = 1'b0;
        err  = 4'sd0;
        if (r_sens1 == '0 && r_last_err != 4'sd0) begin
            lost = 1'b1;
            err  = r_last_err[ERR_W-1] ? -4'sd5 : 4'sd5;
        end else if (r_sens1[3] && r_sens1[4]) begin
            err = 4'sd0;
        end else if (r_sens1[5] && !r_sens1[6]) begin
            err = 4'sd1;
        end else if (r_sens1[2] && !r_sens1[1]) begin
            err = -4'sd1;
        end else if (r_sens1[5] && r_sens1[6] && !r_sens1[7]) begin
            err = 4'sd2;
        end else if (r_sens1[2] && r_sens1[1]) begin
            err = -4'sd2;
        end else if (r_sens1[6] && r_sens1[7]) begin
            err = 4'sd3;
        end else if (r_sens1[1] && r_sens1[0]) begin
            err = -4'sd3;
        end else if (!r_sens1[6] && r_sens1[7]) begin
            err = 4'sd4;
        end else if (!r_sens1[1] && r_sens1[0]) begin
            err = -4'sd4;
        end
    end

    always_comb begin
        sum_wide = (SUM_WIDTH+1)'(r_err_sum) + (SUM_WIDTH+1)'(err);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
        // a lost line leaves the integral alone
        n_err_sum = lost ? r_err_sum : sum_sat;
        gp        = lost ? r_gain_p_sharp : r_gain_p;
        gd        = lost ? r_gain_d_sharp : r_gain_d;
        if (lost) begin
            dterm = err[ERR_W-1] ? -5'sd1 : 5'sd1;
        end else begin
            dterm = (ERR_W+1)'(err) - (ERR_W+1)'(r_last_err);
        end
        prod_p = gp * err;
        prod_d = gd * dterm;
        prod_i = r_gain_i * n_err_sum;
        acc    = ACC_W'(prod_p) + ACC_W'(prod_d) + ACC_W'(prod_i);
        acc_hi = acc[ACC_W-1:PID_W-1];
        if ((&acc_hi) || !(|acc_hi)) begin
            n_held = acc[PID_W-1:0];
        end else begin
            n_held = acc[ACC_W-1] ? {1'b1, {(PID_W-1){1'b0}}} : {1'b0, {(PID_W-1){1'b1}}};
        end
    end

    always_comb begin
        right_sum = WHL_W'(signed'({1'b0, r_base})) + WHL_W'(r_held);
        left_sum  = WHL_W'(signed'({1'b0, r_base})) - WHL_W'(r_held);
        right_w   = f_wheel(right_sum);
        left_w    = f_wheel(left_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_last_err <= '0;
            r_err_sum  <= '0;
            r_held     <= '0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
                // update only on a due sample; otherwise hold
                if (r_v1 && r_due1) begin
                    r_last_err <= err;
                    r_err_sum  <= n_err_sum;
                    r_held     <= n_held;
                end
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_sens1 <= i_in.sensor_bits;
            r_due1  <= i_in.sample_due;
        end
        if (adv3) begin
            r_out_err  <= r_last_err;
            r_out_pid  <= r_held;
            r_out_rspd <= right_w[SPEED_W-1:0];
            r_out_rrev <= right_w[SPEED_W];
            r_out_lspd <= left_w[SPEED_W-1:0];
            r_out_lrev <= left_w[SPEED_W];
        end
    end

    assign o_out.valid          = r_v3;
    assign o_out.position_error = r_out_err;
    assign o_out.pid_value      = r_out_pid;
    assign o_out.right_speed    = r_out_rspd;
    assign o_out.right_reverse  = r_out_rrev;
    assign o_out.left_speed     = r_out_lspd;
    assign o_out.left_reverse   = r_out_lrev;

endmodule

@@ hdl/lfps_checker.sv @@
// Port-level checks on the steering block, bound to its top level.
module lfps_checker import lfps_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [ERR_W-1:0] i_position_error,
    input logic signed [PID_W-1:0] i_pid_value,
    input logic [SPEED_W-1:0]      i_right_speed,
    input logic                    i_right_reverse,
    input logic [SPEED_W-1:0]      i_left_speed,
    input logic                    i_left_reverse
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pid_value)
            && $stable(i_position_error))
        else $error("result beat changed while stalled");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_position_error == 4'sd6 || i_position_error == 4'sd7 ||
                          i_position_error == -4'sd8 || i_position_error == -4'sd7 ||
                          i_position_error == -4'sd6))
        else $error("position error outside +/-5");

    // reverse means a negative sum, so the magnitude cannot be zero
    a_reverse_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_right_reverse || i_right_speed != '0) &&
                        (!i_left_reverse || i_left_speed != '0))
        else $error("reverse flagged with zero speed");

    a_zero_pid_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pid_value == '0 |-> i_right_speed == i_left_speed &&
                                             i_right_reverse == i_left_reverse)
        else $error("wheels differ with zero correction");

    a_ready_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind line_follower_pid_steer_top lfps_checker u_lfps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_position_error (o_out.position_error),
    .i_pid_value      (o_out.pid_value),
    .i_right_speed    (o_out.right_speed),
    .i_right_reverse  (o_out.right_reverse),
    .i_left_speed     (o_out.left_speed),
    .i_left_reverse   (o_out.left_reverse)
);
